@@ rtl/core/sra_pkg.sv @@
// Shared types and constants for the selective-repeat link controller.
// Holds the command and result structs exchanged between front, back and result queue.
// No dependencies.
`default_nettype none
package sra_pkg;

  localparam int SEQ_W      = 6;
  localparam int MAX_SEQ    = 63;
  localparam int WIN        = 32;
  localparam int SLOT_W     = 5;
  localparam int LEN_W      = 11;
  localparam int HDR_LEN    = 7;
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [2:0] MODE_PKT  = 3'd0;
  localparam logic [2:0] MODE_PHY  = 3'd1;
  localparam logic [2:0] MODE_RX   = 3'd2;
  localparam logic [2:0] MODE_DTO  = 3'd3;
  localparam logic [2:0] MODE_ATO  = 3'd4;
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  typedef enum logic [3:0] {
    OP_PKT,
    OP_PHY,
    OP_DATA_GOOD,
    OP_DATA_BAD,
    OP_ACK,
    OP_NAK,
    OP_DTO,
    OP_ATO,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    ACT_DATA    = 3'd0,
    ACT_NAK     = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_NONE    = 3'd5
  } act_e;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] seq;
    logic [7:0]       ack;
    logic [LEN_W-1:0] plen;
  } cmd_t;

  typedef struct packed {
    act_e              action;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  pb_ack;
    logic [SEQ_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  plen;
    logic              net_en;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/sra_front.sv @@
// Front end: accepts events, classifies them into commands and queues them.
// Depends on sra_pkg for the command type and constants.
`default_nettype none
module sra_front #(
  parameter int DEPTH = sra_pkg::CMDQ_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        mode_i,
  input  wire logic [1:0]        frame_kind_i,
  input  wire logic [7:0]        frame_seq_i,
  input  wire logic [7:0]        ack_byte_i,
  input  wire logic              crc_good_i,
  input  wire logic [10:0]       frame_length_i,
  input  wire logic [5:0]        timeout_seq_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output sra_pkg::cmd_t          cmd_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sra_pkg::cmd_t cmd_in;
  sra_pkg::cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  always_comb begin
    cmd_in.seq  = frame_seq_i[sra_pkg::SEQ_W-1:0];
    cmd_in.ack  = ack_byte_i;
    cmd_in.plen = (frame_length_i >= 11'(sra_pkg::HDR_LEN)) ?
                  frame_length_i - 11'(sra_pkg::HDR_LEN) : '0;
    cmd_in.op   = sra_pkg::OP_IGNORE;
    case (mode_i)
      sra_pkg::MODE_PKT: cmd_in.op = sra_pkg::OP_PKT;
      sra_pkg::MODE_PHY: cmd_in.op = sra_pkg::OP_PHY;
      sra_pkg::MODE_RX: begin
        if (frame_seq_i <= 8'(sra_pkg::MAX_SEQ)) begin
          case (frame_kind_i)
            sra_pkg::KIND_DATA:
              cmd_in.op = crc_good_i ? sra_pkg::OP_DATA_GOOD : sra_pkg::OP_DATA_BAD;
            sra_pkg::KIND_ACK: cmd_in.op = crc_good_i ? sra_pkg::OP_ACK : sra_pkg::OP_IGNORE;
            sra_pkg::KIND_NAK: cmd_in.op = crc_good_i ? sra_pkg::OP_NAK : sra_pkg::OP_IGNORE;
            default:           cmd_in.op = sra_pkg::OP_IGNORE;
          endcase
        end
      end
      sra_pkg::MODE_DTO: begin
        cmd_in.op  = sra_pkg::OP_DTO;
        cmd_in.seq = timeout_seq_i;
      end
      sra_pkg::MODE_ATO: cmd_in.op = sra_pkg::OP_ATO;
      default:  cmd_in.op = sra_pkg::OP_IGNORE;
    endcase
  end

  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sra_back.sv @@
// Back end: holds the window state and carries out one command at a time.
// Emits one result per cycle while the result queue accepts it. Depends on sra_pkg.
`default_nettype none
module sra_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire sra_pkg::cmd_t cmd_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output sra_pkg::res_t      res_o
);

  localparam int SW = sra_pkg::SEQ_W;
  localparam int LW = sra_pkg::SLOT_W;
  localparam logic [SW-1:0] WIN_S = SW'(sra_pkg::WIN);
  localparam logic [SW-1:0] ONE   = SW'(1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e state_q, state_d;
  logic [SW-1:0] rl_q, rl_d, rh_q, rh_d, sl_q, sl_d, sn_q, sn_d, out_q, out_d;
  logic lr_q, lr_d;
  logic [(1 << SW)-1:0] nak_q, nak_d;
  logic [sra_pkg::WIN-1:0] sf_q, sf_d;
  logic nak1_q, nak1_d, nak2_q, nak2_d, main_q, main_d, dlv_q, dlv_d, rel_q, rel_d;
  logic [SW-1:0] nak1_seq_q, nak1_seq_d, nak2_seq_q, nak2_seq_d;
  sra_pkg::res_t main_res_q, main_res_d;
  logic [SW-1:0] rel_first_q, rel_first_d, rel_cnt_q, rel_cnt_d;
  logic [sra_pkg::LEN_W-1:0] plen_q, plen_d;
  logic ne_q, ne_d;

  logic [SW-1:0] pb, ack6, rcnt, slot_rl;
  logic rel_in, nak_rl, accept, lr_f;
  sra_pkg::res_t res, blank;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res;
  assign pb          = rl_q - ONE;
  assign ack6        = cmd_i.ack[SW-1:0];
  assign slot_rl     = rl_q;

  always_comb begin
    if (cmd_i.ack <= 8'(sra_pkg::MAX_SEQ)) begin
      rel_in = (ack6 - sl_q) < out_q;
      rcnt   = ack6 - sl_q + ONE;
    end else begin
      rel_in = sn_q < sl_q;
      rcnt   = SW'(0) - sl_q;
    end
  end

  assign nak_rl = (cmd_i.seq != rl_q) && nak_q[rl_q];
  assign accept = ((cmd_i.seq - rl_q) < (rh_q - rl_q)) && !sf_q[cmd_i.seq[LW-1:0]];

  always_comb begin
    blank        = '0;
    blank.action = sra_pkg::ACT_NONE;
    state_d = state_q;
    rl_d = rl_q; rh_d = rh_q; sl_d = sl_q; sn_d = sn_q; out_d = out_q; lr_d = lr_q;
    nak_d = nak_q; sf_d = sf_q;
    nak1_d = nak1_q; nak2_d = nak2_q; main_d = main_q; dlv_d = dlv_q; rel_d = rel_q;
    nak1_seq_d = nak1_seq_q; nak2_seq_d = nak2_seq_q; main_res_d = main_res_q;
    rel_first_d = rel_first_q; rel_cnt_d = rel_cnt_q; plen_d = plen_q; ne_d = ne_q;
    lr_f = lr_q;
    res  = blank;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_EMIT;
          nak1_d = 1'b0; nak2_d = 1'b0; main_d = 1'b0; dlv_d = 1'b0; rel_d = 1'b0;
          main_res_d = blank;
          plen_d = cmd_i.plen;
          ne_d = (out_q < WIN_S) && lr_q;
          case (cmd_i.op)
            sra_pkg::OP_PKT: begin
              main_d = 1'b1;
              ne_d = 1'b0;
              if (out_q < WIN_S) begin
                main_res_d.action = sra_pkg::ACT_DATA;
                main_res_d.seq    = sn_q;
                main_res_d.pb_ack = pb;
                main_res_d.slot   = sn_q[LW-1:0];
                sn_d  = sn_q + ONE;
                out_d = out_q + ONE;
                lr_d  = 1'b0;
              end
            end
            sra_pkg::OP_PHY: begin
              main_d = 1'b1;
              lr_d = 1'b1;
              ne_d = (out_q < WIN_S);
            end
            sra_pkg::OP_DTO: begin
              main_d = 1'b1;
              main_res_d.action = sra_pkg::ACT_DATA;
              main_res_d.seq    = cmd_i.seq;
              main_res_d.pb_ack = pb;
              main_res_d.slot   = cmd_i.seq[LW-1:0];
              lr_d = 1'b0;
              ne_d = 1'b0;
            end
            sra_pkg::OP_ATO: begin
              main_d = 1'b1;
              main_res_d.action = sra_pkg::ACT_ACK;
              main_res_d.pb_ack = pb;
              lr_d = 1'b0;
              ne_d = 1'b0;
            end
            sra_pkg::OP_NAK: begin
              main_d = 1'b1;
              if ((cmd_i.seq - sl_q) < out_q) begin
                main_res_d.action = sra_pkg::ACT_DATA;
                main_res_d.seq    = cmd_i.seq;
                main_res_d.pb_ack = pb;
                main_res_d.slot   = cmd_i.seq[LW-1:0];
                lr_d = 1'b0;
                ne_d = 1'b0;
              end
            end
            sra_pkg::OP_DATA_BAD: begin
              nak_d[cmd_i.seq] = 1'b0;
              nak1_d = 1'b1;
              nak1_seq_d = cmd_i.seq;
              if (nak_rl) begin
                nak2_d = 1'b1;
                nak2_seq_d = rl_q;
                nak_d[rl_q] = 1'b0;
              end
              lr_d = 1'b0;
              ne_d = 1'b0;
            end
            sra_pkg::OP_DATA_GOOD: begin
              nak_d[cmd_i.seq] = 1'b1;
              if (nak_rl) begin
                nak1_d = 1'b1;
                nak1_seq_d = rl_q;
                nak_d[rl_q] = 1'b0;
                lr_d = 1'b0;
                lr_f = 1'b0;
              end
              if (accept) begin
                sf_d[cmd_i.seq[LW-1:0]] = 1'b1;
                dlv_d = sf_d[slot_rl[LW-1:0]];
              end
              if (rel_in) begin
                rel_d = 1'b1;
                rel_first_d = sl_q;
                rel_cnt_d = rcnt;
                sl_d  = sl_q + rcnt;
                out_d = out_q - rcnt;
              end
              ne_d = (out_d < WIN_S) && lr_f;
              main_d = !(nak_rl || dlv_d || rel_in);
            end
            sra_pkg::OP_ACK: begin
              if (rel_in) begin
                rel_d = 1'b1;
                rel_first_d = sl_q;
                rel_cnt_d = rcnt;
                sl_d  = sl_q + rcnt;
                out_d = out_q - rcnt;
              end
              ne_d = (out_d < WIN_S) && lr_q;
              main_d = !rel_in;
            end
            default: main_d = 1'b1;
          endcase
        end
      end
      ST_EMIT: begin
        if (nak1_q) begin
          res.action = sra_pkg::ACT_NAK;
          res.seq    = nak1_seq_q;
          nak1_d = 1'b0;
        end else if (nak2_q) begin
          res.action = sra_pkg::ACT_NAK;
          res.seq    = nak2_seq_q;
          nak2_d = 1'b0;
        end else if (main_q) begin
          res = main_res_q;
          main_d = 1'b0;
        end else if (dlv_q) begin
          res.action = sra_pkg::ACT_DELIVER;
          res.seq    = rl_q;
          res.slot   = rl_q[LW-1:0];
          res.plen   = plen_q;
          sf_d[rl_q[LW-1:0]] = 1'b0;
          rl_d = rl_q + ONE;
          rh_d = rh_q + ONE;
          dlv_d = sf_q[rl_d[LW-1:0]];
        end else begin
          res.action = sra_pkg::ACT_RELEASE;
          res.seq    = rel_first_q;
          res.count  = rel_cnt_q;
          rel_d = 1'b0;
        end
        res.net_en = ne_q;
        res.last   = !(nak1_d || nak2_d || main_d || dlv_d || rel_d);
        if (!res_ready_i) begin
          nak1_d = nak1_q; nak2_d = nak2_q; main_d = main_q; dlv_d = dlv_q; rel_d = rel_q;
          sf_d = sf_q; rl_d = rl_q; rh_d = rh_q;
        end else if (res.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rl_q    <= '0;
      rh_q    <= WIN_S;
      sl_q    <= '0;
      sn_q    <= '0;
      out_q   <= '0;
      lr_q    <= 1'b0;
      nak_q   <= '1;
      sf_q    <= '0;
      nak1_q  <= 1'b0;
      nak2_q  <= 1'b0;
      main_q  <= 1'b0;
      dlv_q   <= 1'b0;
      rel_q   <= 1'b0;
      ne_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rl_q    <= rl_d;
      rh_q    <= rh_d;
      sl_q    <= sl_d;
      sn_q    <= sn_d;
      out_q   <= out_d;
      lr_q    <= lr_d;
      nak_q   <= nak_d;
      sf_q    <= sf_d;
      nak1_q  <= nak1_d;
      nak2_q  <= nak2_d;
      main_q  <= main_d;
      dlv_q   <= dlv_d;
      rel_q   <= rel_d;
      ne_q    <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nak1_seq_q  <= nak1_seq_d;
    nak2_seq_q  <= nak2_seq_d;
    main_res_q  <= main_res_d;
    rel_first_q <= rel_first_d;
    rel_cnt_q   <= rel_cnt_d;
    plen_q      <= plen_d;
  end

`ifndef NO_ASSERTIONS
  a_recv_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rh_q == rl_q + WIN_S) else $error("receive window edges drifted apart");
  a_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q == sn_q - sl_q) else $error("outstanding count disagrees with send window");
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q <= WIN_S) else $error("outstanding count exceeds window");
`endif

endmodule
`default_nettype wire

@@ rtl/core/sra_outq.sv @@
// Result queue between the back end and the result ports.
// Depends on sra_pkg for the result type and queue depth.
`default_nettype none
module sra_outq #(
  parameter int DEPTH = sra_pkg::OUTQ_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  output logic               res_ready_o,
  input  wire sra_pkg::res_t res_i,
  output logic               empty,
  input  wire logic          pop,
  output sra_pkg::res_t      res_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sra_pkg::res_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign res_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign empty       = (cnt_q == '0);
  assign res_o       = mem_q[rd_q];
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/selective_repeat_arq_controller.sv @@
// Top level of the selective-repeat link controller core.
// Instantiates sra_front, sra_back and sra_outq; depends on sra_pkg.
//
//   channel  | handshake          | payload
//   events   | push / full        | mode, frame_kind, frame_seq, ack_byte, crc_good,
//            |                    | frame_length, timeout_seq
//   results  | empty / pop        | action, seq_number, piggyback_ack, release_count,
//            |                    | buffer_slot, payload_length, network_enable, last
//
// An event takes a setup step in the back end, which then emits its results one after
// another; a full in-order delivery run gives the longest stream of results.
// The back end's single result port sets the pace; the front queue holds two events.
// Reset resets the window state, sets all NAK-allowed bits and clears the arrival bitmap.
// A full result queue stalls the back end; a full event queue raises full.
`default_nettype none
module selective_repeat_arq_controller #(
  parameter int CMD_DEPTH = sra_pkg::CMDQ_DEPTH,
  parameter int RES_DEPTH = sra_pkg::OUTQ_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  mode_i,
  input  wire logic [1:0]  frame_kind_i,
  input  wire logic [7:0]  frame_seq_i,
  input  wire logic [7:0]  ack_byte_i,
  input  wire logic        crc_good_i,
  input  wire logic [10:0] frame_length_i,
  input  wire logic [5:0]  timeout_seq_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       action_o,
  output logic [5:0]       seq_number_o,
  output logic [5:0]       piggyback_ack_o,
  output logic [5:0]       release_count_o,
  output logic [4:0]       buffer_slot_o,
  output logic [10:0]      payload_length_o,
  output logic             network_enable_o,
  output logic             last_o
);

  sra_pkg::cmd_t cmd;
  sra_pkg::res_t res_back, res_out;
  logic cmd_valid, cmd_ready, res_valid, res_ready;

  sra_front #(.DEPTH(CMD_DEPTH)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .mode_i, .frame_kind_i, .frame_seq_i, .ack_byte_i, .crc_good_i,
    .frame_length_i, .timeout_seq_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sra_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res_back)
  );

  sra_outq #(.DEPTH(RES_DEPTH)) u_outq (
    .clk_i, .rst_ni,
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res_back),
    .empty, .pop,
    .res_o       (res_out)
  );

  assign action_o         = res_out.action;
  assign seq_number_o     = res_out.seq;
  assign piggyback_ack_o  = res_out.pb_ack;
  assign release_count_o  = res_out.count;
  assign buffer_slot_o    = res_out.slot;
  assign payload_length_o = res_out.plen;
  assign network_enable_o = res_out.net_en;
  assign last_o           = res_out.last;

endmodule
`default_nettype wire

@@ sim/tb_checker.sv @@
// Checker for the selective-repeat link controller: watches both channels, predicts results.
// Holds its own copy of the window state and compares each result transaction field by field.
// Depends on sra_pkg.
`default_nettype none
module tb_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [1:0]  frame_kind_i,
  input  wire logic [7:0]  frame_seq_i,
  input  wire logic [7:0]  ack_byte_i,
  input  wire logic        crc_good_i,
  input  wire logic [10:0] frame_length_i,
  input  wire logic [5:0]  timeout_seq_i,
  input  wire logic        empty_i,
  input  wire logic        pop_i,
  input  wire logic [2:0]  action_i,
  input  wire logic [5:0]  seq_number_i,
  input  wire logic [5:0]  piggyback_ack_i,
  input  wire logic [5:0]  release_count_i,
  input  wire logic [4:0]  buffer_slot_i,
  input  wire logic [10:0] payload_length_i,
  input  wire logic        network_enable_i,
  input  wire logic        last_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int MAX_RES = 35;

  sra_pkg::res_t cmd_queue[$];
  sra_pkg::res_t event_cmds[$];
  logic [5:0]    rx_low, rx_high, tx_low, tx_next;
  int            in_flight;
  logic          phy_ready;
  logic          nak_ok[64];
  logic          arrived[32];

  assign pending_o = cmd_queue.size();

  function automatic logic between(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic void add_cmd(sra_pkg::act_e act, logic [5:0] sq, logic [5:0] pb,
                                  logic [5:0] cnt, logic [4:0] slot, logic [10:0] plen);
    sra_pkg::res_t r;
    if (event_cmds.size() >= MAX_RES) return;
    r = '{action: act, seq: sq, pb_ack: pb, count: cnt, slot: slot, plen: plen,
          net_en: 1'b0, last: 1'b0};
    event_cmds.push_back(r);
  endfunction

  function automatic void tx_data(logic [5:0] sq);
    add_cmd(sra_pkg::ACT_DATA, sq, rx_low - 6'd1, '0, sq[4:0], '0);
    phy_ready = 1'b0;
  endfunction

  function automatic void tx_nak(logic [5:0] sq);
    nak_ok[sq] = 1'b0;
    add_cmd(sra_pkg::ACT_NAK, sq, '0, '0, '0, '0);
    phy_ready = 1'b0;
  endfunction

  function automatic void free_acked(logic [7:0] ack);
    logic [5:0] first;
    int         cnt;
    first = tx_low;
    cnt = 0;
    while (in_flight > 0 && between({2'b0, tx_low}, ack, {2'b0, tx_next})) begin
      tx_low++;
      in_flight--;
      cnt++;
    end
    if (cnt > 0) add_cmd(sra_pkg::ACT_RELEASE, first, '0, 6'(cnt), '0, '0);
  endfunction

  function automatic void predict_event(logic [2:0] md, logic [1:0] kind, logic [7:0] sq,
                                        logic [7:0] ack, logic good, logic [10:0] len,
                                        logic [5:0] tsq);
    logic [10:0] plen;
    logic        ne;
    event_cmds.delete();
    case (md)
      sra_pkg::MODE_PKT: begin
        if (in_flight < sra_pkg::WIN) begin
          tx_data(tx_next);
          in_flight++;
          tx_next++;
        end
      end
      sra_pkg::MODE_PHY: phy_ready = 1'b1;
      sra_pkg::MODE_RX: begin
        if (sq <= sra_pkg::MAX_SEQ) begin
          if (kind == sra_pkg::KIND_DATA) begin
            nak_ok[sq[5:0]] = 1'b1;
            if (!good) begin
              if (nak_ok[sq[5:0]]) tx_nak(sq[5:0]);
              if (nak_ok[rx_low]) tx_nak(rx_low);
            end else begin
              if (sq[5:0] != rx_low && nak_ok[rx_low]) tx_nak(rx_low);
              if (between({2'b0, rx_low}, sq, {2'b0, rx_high}) && !arrived[sq[4:0]]) begin
                plen = (len >= 11'd7) ? len - 11'd7 : 11'd0;
                arrived[sq[4:0]] = 1'b1;
                while (arrived[rx_low[4:0]]) begin
                  arrived[rx_low[4:0]] = 1'b0;
                  add_cmd(sra_pkg::ACT_DELIVER, rx_low, '0, '0, rx_low[4:0], plen);
                  rx_low++;
                  rx_high++;
                end
              end
              free_acked(ack);
            end
          end else if (kind == sra_pkg::KIND_ACK) begin
            if (good) free_acked(ack);
          end else if (kind == sra_pkg::KIND_NAK) begin
            if (good && between({2'b0, tx_low}, sq, {2'b0, tx_next})) tx_data(sq[5:0]);
          end
        end
      end
      sra_pkg::MODE_DTO: tx_data(tsq);
      sra_pkg::MODE_ATO: begin
        add_cmd(sra_pkg::ACT_ACK, '0, rx_low - 6'd1, '0, '0, '0);
        phy_ready = 1'b0;
      end
      default: ;
    endcase
    if (event_cmds.size() == 0) add_cmd(sra_pkg::ACT_NONE, '0, '0, '0, '0, '0);
    ne = (in_flight < sra_pkg::WIN) && phy_ready;
    foreach (event_cmds[k]) begin
      event_cmds[k].net_en = ne;
      event_cmds[k].last = (k == event_cmds.size() - 1);
      cmd_queue.push_back(event_cmds[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sra_pkg::res_t got, want;
    if (!rst_ni) begin
      rx_low = '0;
      rx_high = 6'(sra_pkg::WIN);
      tx_low = '0;
      tx_next = '0;
      in_flight = 0;
      phy_ready = 1'b0;
      foreach (nak_ok[i]) nak_ok[i] = 1'b1;
      foreach (arrived[i]) arrived[i] = 1'b0;
      cmd_queue.delete();
      errors_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        got = '{action: sra_pkg::act_e'(action_i), seq: seq_number_i,
                pb_ack: piggyback_ack_i, count: release_count_i, slot: buffer_slot_i,
                plen: payload_length_i, net_en: network_enable_i, last: last_i};
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (push_i && !full_i)
        predict_event(mode_i, frame_kind_i, frame_seq_i, ack_byte_i, crc_good_i,
                      frame_length_i, timeout_seq_i);
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench top for the selective-repeat link controller: clock, reset, event stimulus, verdict.
// Instantiates selective_repeat_arq_controller and tb_checker; depends on sra_pkg.
`default_nettype none
module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [2:0]  mode_i = '0;
  logic [1:0]  frame_kind_i = '0;
  logic [7:0]  frame_seq_i = '0;
  logic [7:0]  ack_byte_i = '0;
  logic        crc_good_i = 1'b0;
  logic [10:0] frame_length_i = '0;
  logic [5:0]  timeout_seq_i = '0;
  logic [2:0]  action_o;
  logic [5:0]  seq_number_o, piggyback_ack_o, release_count_o;
  logic [4:0]  buffer_slot_o;
  logic [10:0] payload_length_o;
  logic        network_enable_o, last_o;
  int          errors, pending, idle_cycles;
  bit          stim_done = 1'b0;
  bit          hold_off = 1'b0;
  logic [5:0]  peer_next = '0;
  logic [5:0]  my_next = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  selective_repeat_arq_controller i_dut (.*);

  tb_checker i_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .mode_i, .frame_kind_i, .frame_seq_i,
    .ack_byte_i, .crc_good_i, .frame_length_i, .timeout_seq_i, .empty_i(empty),
    .pop_i(pop), .action_i(action_o), .seq_number_i(seq_number_o),
    .piggyback_ack_i(piggyback_ack_o), .release_count_i(release_count_o),
    .buffer_slot_i(buffer_slot_o), .payload_length_i(payload_length_o),
    .network_enable_i(network_enable_o), .last_i(last_o), .errors_o(errors),
    .pending_o(pending)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_event(logic [2:0] md, logic [1:0] kind, logic [7:0] sq, logic [7:0] ack,
                            logic good, logic [10:0] len, logic [5:0] tsq, bit may_gap);
    int gap;
    gap = may_gap ? gap_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= md;
    frame_kind_i <= kind;
    frame_seq_i <= sq;
    ack_byte_i <= ack;
    crc_good_i <= good;
    frame_length_i <= len;
    timeout_seq_i <= tsq;
    do @(posedge clk_i); while (full);
  endtask

  // Mostly well-formed traffic: in-order peer data, acks for our frames, with some noise.
  task automatic random_event(bit may_gap);
    int pick;
    logic [7:0] sq;
    pick = $urandom_range(0, 99);
    sq = {2'b0, peer_next + 6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0)};
    if (pick < 20) begin
      send_event(sra_pkg::MODE_PKT, '0, 8'($urandom), 8'($urandom), 1'($urandom),
                 11'($urandom), 6'($urandom), may_gap);
      my_next++;
    end else if (pick < 30) begin
      send_event(sra_pkg::MODE_PHY, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                 11'($urandom), 6'($urandom), may_gap);
    end else if (pick < 65) begin
      if (sq[5:0] == peer_next) peer_next++;
      send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, sq,
                 {2'b0, my_next - 6'($urandom_range(1, 4))},
                 $urandom_range(0, 7) != 0, 11'($urandom), 6'($urandom), may_gap);
    end else if (pick < 75) begin
      send_event(sra_pkg::MODE_RX, sra_pkg::KIND_ACK, 8'($urandom_range(0, 63)),
                 (pick & 1) ? 8'($urandom) : {2'b0, my_next - 6'($urandom_range(1, 8))},
                 $urandom_range(0, 5) != 0, 11'($urandom), 6'($urandom), may_gap);
    end else if (pick < 82) begin
      send_event(sra_pkg::MODE_RX, sra_pkg::KIND_NAK, 8'($urandom_range(0, 63)),
                 8'($urandom), $urandom_range(0, 5) != 0, 11'($urandom), 6'($urandom),
                 may_gap);
    end else if (pick < 88) begin
      send_event(sra_pkg::MODE_RX, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                 11'($urandom), 6'($urandom), may_gap);
    end else if (pick < 93) begin
      send_event(sra_pkg::MODE_DTO, '0, '0, '0, 1'b0, '0, 6'($urandom), may_gap);
    end else if (pick < 97) begin
      send_event(sra_pkg::MODE_ATO, '0, '0, '0, 1'b0, '0, 6'($urandom), may_gap);
    end else begin
      send_event(3'($urandom_range(5, 7)), 2'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom), 11'($urandom), 6'($urandom), may_gap);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed part: fill the send window past full, ignored events, bad CRC NAK quirk,
    // out-of-order then in-order delivery, large ack bytes, length saturation.
    send_event(sra_pkg::MODE_PHY, '0, '0, '0, 1'b1, '0, '0, 0);
    for (int i = 0; i < 33; i++) send_event(sra_pkg::MODE_PKT, '0, '0, '0, 1'b0, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_NAK, 8'd5, 8'd0, 1'b1, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_NAK, 8'd5, 8'd0, 1'b0, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_ACK, 8'd0, 8'd255, 1'b1, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_ACK, 8'd0, 8'd9, 1'b1, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, 8'd255, 8'd0, 1'b1, 11'd2047, '0, 0);
    send_event(sra_pkg::MODE_RX, 2'd3, 8'd1, 8'd0, 1'b1, '0, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, 8'd3, 8'd0, 1'b0, 11'd100, '0, 0);
    for (int i = 31; i >= 1; i--)
      send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, 8'(i), 8'd200, 1'b1, 11'(i), '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, 8'd0, 8'd31, 1'b1, 11'd3, '0, 0);
    send_event(sra_pkg::MODE_RX, sra_pkg::KIND_DATA, 8'd40, 8'd31, 1'b1, 11'd2047, '0, 0);
    send_event(sra_pkg::MODE_DTO, '0, '0, '0, 1'b0, '0, 6'd63, 0);
    send_event(sra_pkg::MODE_ATO, '0, '0, '0, 1'b0, '0, '0, 0);
    send_event(3'd7, 2'd3, 8'hff, 8'hff, 1'b1, 11'h7ff, 6'h3f, 0);
    peer_next = 6'd32;
    my_next = 6'd33;
    // Long receiver hold-off while events keep coming.
    hold_off <= 1'b1;
    for (int i = 0; i < 20; i++) random_event(0);
    hold_off <= 1'b0;
    for (int i = 0; i < 313; i++) random_event(1);
    push <= 1'b0;
    @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        held = 1'b1;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && pending == 0) begin
        repeat (50) @(posedge clk_i);
        if (errors == 0 && pending == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("TEST FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/sra_pkg.sv
rtl/core/sra_front.sv
rtl/core/sra_back.sv
rtl/core/sra_outq.sv
rtl/core/selective_repeat_arq_controller.sv
sim/tb_checker.sv
sim/tb_top.sv
